// ----- sv/star_wildcard_match_core_defines.svh -----
// Assertion macros for the star wildcard matcher.
// Included by swm_seq, the module that carries the concurrent assertions; depends on clk and rst.
`ifndef STAR_WILDCARD_MATCH_CORE_DEFINES_SVH
`define STAR_WILDCARD_MATCH_CORE_DEFINES_SVH

// Implication in the same cycle.
`define SWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/swm_pkg.sv -----
// Shared types and constants for the star wildcard matcher.
// Used by swm_buf, swm_seq and star_wildcard_match_core; no dependencies.
package swm_pkg;

  localparam int MAX_LEN_DEF = 256;
  localparam logic [7:0] STAR_BYTE = 8'd42;

  // Action codes of an input item; the fourth code is ignored.
  localparam logic [1:0] ACT_PATTERN = 2'd0;
  localparam logic [1:0] ACT_NAME    = 2'd1;
  localparam logic [1:0] ACT_EVAL    = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } result_t;

  typedef struct packed {
    logic go;
    logic overflow;
  } eval_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } eval_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_PLAN,
    ST_RUN_RD,
    ST_RUN_CK,
    ST_SEG_NEXT,
    ST_SEG_RD,
    ST_SEG_CK,
    ST_SEG_TRY,
    ST_DONE
  } state_t;

  // What a finished run comparison returns to.
  typedef enum logic [1:0] {
    CTX_EXACT,
    CTX_PREFIX,
    CTX_SUFFIX,
    CTX_SEGMENT
  } ctx_t;

endpackage

// ----- sv/swm_buf.sv -----
// Byte buffer: one write port and one read port with registered read data.
// Takes its default depth from swm_pkg; instantiated for the pattern and the name strings.
module swm_buf #(
  parameter int DEPTH = swm_pkg::MAX_LEN_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/swm_seq.sv -----
// Evaluation sequencer: walks both buffers through their read ports and
// decides the match. Depends on swm_pkg and star_wildcard_match_core_defines.svh.
`include "star_wildcard_match_core_defines.svh"

module swm_seq #(
  parameter int MAX_LEN = swm_pkg::MAX_LEN_DEF,
  parameter int AW      = $clog2(MAX_LEN),
  parameter int LW      = $clog2(MAX_LEN + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  swm_pkg::eval_req_t   req,
  input  logic [LW-1:0]        plen_in,
  input  logic [LW-1:0]        nlen_in,
  output logic [AW-1:0]        p_addr,
  output logic [AW-1:0]        n_addr,
  input  logic [7:0]           p_rd,
  input  logic [7:0]           n_rd,
  output swm_pkg::eval_stat_t  stat,
  output swm_pkg::result_t     result
);

  swm_pkg::state_t state, state_next;
  swm_pkg::ctx_t   ctx;

  logic [LW-1:0] plen, nlen;
  logic          ovf;
  logic          matched;
  logic          star_seen;
  logic [LW-1:0] idx, first, last;
  logic [LW-1:0] pa, na, cnt;
  logic [LW-1:0] suffix_len, name_end;
  logic [LW-1:0] seg_start, seg_end, seg_len, pos;

  logic [LW-1:0] suffix_len_c;
  logic [LW:0]   head_tail;
  logic [LW:0]   seg_reach;
  logic          p_is_star;

  assign suffix_len_c = plen - last - 1'b1;
  assign head_tail    = {1'b0, first} + {1'b0, suffix_len_c};
  assign seg_reach    = {1'b0, pos} + {1'b0, seg_len};
  assign p_is_star    = (p_rd == swm_pkg::STAR_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swm_pkg::ST_IDLE: begin
        if (req.go) begin
          state_next = req.overflow ? swm_pkg::ST_DONE : swm_pkg::ST_SCAN_RD;
        end
      end
      swm_pkg::ST_SCAN_RD: begin
        state_next = (idx == plen) ? swm_pkg::ST_PLAN : swm_pkg::ST_SCAN_CK;
      end
      swm_pkg::ST_SCAN_CK: state_next = swm_pkg::ST_SCAN_RD;
      swm_pkg::ST_PLAN: begin
        if (!star_seen) begin
          state_next = (plen != nlen) ? swm_pkg::ST_DONE : swm_pkg::ST_RUN_RD;
        end else begin
          state_next = ({1'b0, nlen} < head_tail) ? swm_pkg::ST_DONE : swm_pkg::ST_RUN_RD;
        end
      end
      swm_pkg::ST_RUN_RD: begin
        if (cnt != '0) begin
          state_next = swm_pkg::ST_RUN_CK;
        end else begin
          case (ctx)
            swm_pkg::CTX_EXACT:  state_next = swm_pkg::ST_DONE;
            swm_pkg::CTX_PREFIX: state_next = swm_pkg::ST_RUN_RD;
            default:             state_next = swm_pkg::ST_SEG_NEXT;
          endcase
        end
      end
      swm_pkg::ST_RUN_CK: begin
        if (p_rd == n_rd) begin
          state_next = swm_pkg::ST_RUN_RD;
        end else if (ctx == swm_pkg::CTX_SEGMENT) begin
          state_next = swm_pkg::ST_SEG_TRY;
        end else begin
          state_next = swm_pkg::ST_DONE;
        end
      end
      swm_pkg::ST_SEG_NEXT: begin
        state_next = (seg_start > last) ? swm_pkg::ST_DONE : swm_pkg::ST_SEG_RD;
      end
      swm_pkg::ST_SEG_RD: state_next = swm_pkg::ST_SEG_CK;
      swm_pkg::ST_SEG_CK: begin
        if (!p_is_star) begin
          state_next = swm_pkg::ST_SEG_RD;
        end else if (seg_end == seg_start) begin
          state_next = swm_pkg::ST_SEG_NEXT;
        end else begin
          state_next = swm_pkg::ST_SEG_TRY;
        end
      end
      swm_pkg::ST_SEG_TRY: begin
        state_next = (seg_reach <= {1'b0, name_end}) ? swm_pkg::ST_RUN_RD : swm_pkg::ST_DONE;
      end
      swm_pkg::ST_DONE: state_next = swm_pkg::ST_IDLE;
      default:          state_next = swm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    p_addr          = '0;
    n_addr          = '0;
    stat.busy       = (state != swm_pkg::ST_IDLE);
    stat.done       = (state == swm_pkg::ST_DONE);
    result.matched  = matched;
    result.overflow = ovf;
    case (state)
      swm_pkg::ST_SCAN_RD: p_addr = idx[AW-1:0];
      swm_pkg::ST_RUN_RD: begin
        p_addr = pa[AW-1:0];
        n_addr = na[AW-1:0];
      end
      swm_pkg::ST_SEG_RD: p_addr = seg_end[AW-1:0];
      default: ;
    endcase
  end

  // Working registers. Every fail path simply leaves matched at zero.
  always_ff @(posedge clk) begin
    case (state)
      swm_pkg::ST_IDLE: begin
        if (req.go) begin
          plen      <= plen_in;
          nlen      <= nlen_in;
          ovf       <= req.overflow;
          matched   <= 1'b0;
          star_seen <= 1'b0;
          idx       <= '0;
        end
      end
      swm_pkg::ST_SCAN_CK: begin
        if (p_is_star) begin
          if (!star_seen) begin
            first <= idx;
          end
          last      <= idx;
          star_seen <= 1'b1;
        end
        idx <= idx + 1'b1;
      end
      swm_pkg::ST_PLAN: begin
        pa <= '0;
        na <= '0;
        if (star_seen) begin
          cnt        <= first;
          ctx        <= swm_pkg::CTX_PREFIX;
          suffix_len <= suffix_len_c;
          name_end   <= nlen - suffix_len_c;
        end else begin
          cnt <= plen;
          ctx <= swm_pkg::CTX_EXACT;
        end
      end
      swm_pkg::ST_RUN_RD: begin
        if (cnt == '0) begin
          case (ctx)
            swm_pkg::CTX_EXACT: matched <= 1'b1;
            swm_pkg::CTX_PREFIX: begin
              pa  <= last + 1'b1;
              na  <= name_end;
              cnt <= suffix_len;
              ctx <= swm_pkg::CTX_SUFFIX;
            end
            swm_pkg::CTX_SUFFIX: begin
              pos       <= first;
              seg_start <= first + 1'b1;
            end
            default: begin
              // The name pointer has already moved past the matched segment.
              pos       <= na;
              seg_start <= seg_end + 1'b1;
            end
          endcase
        end
      end
      swm_pkg::ST_RUN_CK: begin
        if (p_rd == n_rd) begin
          pa  <= pa + 1'b1;
          na  <= na + 1'b1;
          cnt <= cnt - 1'b1;
        end else begin
          pos <= pos + 1'b1;
        end
      end
      swm_pkg::ST_SEG_NEXT: begin
        if (seg_start > last) begin
          matched <= 1'b1;
        end else begin
          seg_end <= seg_start;
        end
      end
      swm_pkg::ST_SEG_CK: begin
        if (!p_is_star) begin
          seg_end <= seg_end + 1'b1;
        end else if (seg_end == seg_start) begin
          seg_start <= seg_end + 1'b1;
        end else begin
          seg_len <= seg_end - seg_start;
        end
      end
      swm_pkg::ST_SEG_TRY: begin
        pa  <= seg_start;
        na  <= pos;
        cnt <= seg_len;
        ctx <= swm_pkg::CTX_SEGMENT;
      end
      default: ;
    endcase
  end

  `SWM_ASSERT_SAME(a_ovf_never_matches, stat.done && result.overflow, !result.matched, "overflow result reports a match")
  `SWM_ASSERT_NEXT(a_go_starts_work, (state == swm_pkg::ST_IDLE) && req.go, stat.busy, "evaluation did not start")
  `SWM_ASSERT_NEXT(a_done_single, stat.done, !stat.done && !stat.busy, "result strobe longer than one cycle")
  `SWM_ASSERT_SAME(a_run_count_live, state == swm_pkg::ST_RUN_CK, cnt != '0, "byte compare with empty run")

endmodule

// ----- sv/star_wildcard_match_core.sv -----
// Star wildcard matcher: top level with load control, buffer lengths and overflow.
// Depends on swm_pkg, swm_buf and swm_seq.
//
// Usage: an item (action, data_byte) is transferred when start is high and busy
// is low. Action pattern or name appends data_byte to that buffer, so loads can
// follow back to back; a byte beyond MAX_LEN is dropped and marks overflow.
// Action evaluate decides whether the whole name matches the pattern
// ('*' matches any run, including an empty one) and clears both buffers; the
// fourth action code is ignored. busy is high from the cycle after an evaluate
// transfer up to and including the result cycle, so the next item is taken in the
// cycle after the result at the earliest.
// An evaluation with overflow goes straight to the result cycle. Otherwise the
// sequencer scans the P pattern bytes for stars, checks the lengths, compares
// the prefix and suffix runs byte pair by byte pair, then walks each middle
// segment up to its closing star and tries its placements one by one, so the
// search can compare up to about P*N bytes for N name bytes. Each buffer has a
// single read port with registered read data. done is high for a single cycle,
// with the result on result; no stall exists.
// Reset (rst, synchronous) empties both buffers and clears overflow; buffer
// contents are not cleared, as only written entries are ever read.
module star_wildcard_match_core #(
  parameter int MAX_LEN = swm_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  swm_pkg::item_t    item,
  output logic              done,
  output swm_pkg::result_t  result
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0] plen, plen_next;
  logic [LW-1:0] nlen, nlen_next;
  logic          ovf_seen, ovf_seen_next;

  logic          accept;
  logic          p_we, n_we;
  logic [AW-1:0] p_addr, n_addr;
  logic [7:0]    p_rd, n_rd;

  swm_pkg::eval_req_t  req;
  swm_pkg::eval_stat_t stat;

  assign accept = start && !stat.busy;
  assign busy   = stat.busy;
  assign done   = stat.done;

  // Loads and reads never overlap: writes are taken only while the sequencer idles.
  assign p_we = accept && (item.action == swm_pkg::ACT_PATTERN) && (plen != LW'(MAX_LEN));
  assign n_we = accept && (item.action == swm_pkg::ACT_NAME) && (nlen != LW'(MAX_LEN));

  assign req.go       = accept && (item.action == swm_pkg::ACT_EVAL);
  assign req.overflow = ovf_seen;

  always_comb begin
    plen_next     = plen;
    nlen_next     = nlen;
    ovf_seen_next = ovf_seen;
    if (accept) begin
      case (item.action)
        swm_pkg::ACT_PATTERN: begin
          if (p_we) begin
            plen_next = plen + 1'b1;
          end else begin
            ovf_seen_next = 1'b1;
          end
        end
        swm_pkg::ACT_NAME: begin
          if (n_we) begin
            nlen_next = nlen + 1'b1;
          end else begin
            ovf_seen_next = 1'b1;
          end
        end
        swm_pkg::ACT_EVAL: begin
          plen_next     = '0;
          nlen_next     = '0;
          ovf_seen_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen     <= '0;
      nlen     <= '0;
      ovf_seen <= 1'b0;
    end else begin
      plen     <= plen_next;
      nlen     <= nlen_next;
      ovf_seen <= ovf_seen_next;
    end
  end

  swm_buf #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_pattern_buf (
    .clk   (clk),
    .we    (p_we),
    .waddr (plen[AW-1:0]),
    .wdata (item.data_byte),
    .raddr (p_addr),
    .rdata (p_rd)
  );

  swm_buf #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_name_buf (
    .clk   (clk),
    .we    (n_we),
    .waddr (nlen[AW-1:0]),
    .wdata (item.data_byte),
    .raddr (n_addr),
    .rdata (n_rd)
  );

  swm_seq #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .LW      (LW)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .plen_in (plen),
    .nlen_in (nlen),
    .p_addr  (p_addr),
    .n_addr  (n_addr),
    .p_rd    (p_rd),
    .n_rd    (n_rd),
    .stat    (stat),
    .result  (result)
  );

endmodule
